### hdl/qrs_pkg.sv
// Shared widths, codes and control types of the quadratic root solver.
// Depends on nothing; every other file of the solver imports it.
package qrs_pkg;

   localparam int COEF_W            = 32;
   localparam int TERM_W            = 3;
   localparam int EPS_W             = 32;
   localparam int ROOT_W            = 48;
   localparam int STATUS_W          = 2;
   localparam int COUNT_W           = 2;
   localparam int FRAC_BITS_DEFAULT = 16;

   // Magnitude of b*b - 4*a*c stays below 2^65.
   localparam int DISC_W = 66;
   // Signed divisor: 2*a or b.
   localparam int DEN_W  = COEF_W + 2;

   localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(43);

   localparam logic [TERM_W-1:0] TERMS_NONE   = TERM_W'(0);
   localparam logic [TERM_W-1:0] TERMS_CONST  = TERM_W'(1);
   localparam logic [TERM_W-1:0] TERMS_LINEAR = TERM_W'(2);
   localparam logic [TERM_W-1:0] TERMS_QUAD   = TERM_W'(3);

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK         = 2'd0,
      STATUS_INFINITE   = 2'd1,
      STATUS_BAD_DEGREE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      MODE_NONE,
      MODE_LINEAR,
      MODE_SINGLE,
      MODE_DOUBLE
   } mode_type;

   typedef struct packed {
      logic                valid;
      status_type          status;
      logic [COUNT_W-1:0]  root_count;
      mode_type            mode;
   } ctrl_type;

endpackage

### hdl/quadratic_root_solver.sv
// Top level of the quadratic root solver: tolerance register, numerator stage,
// two divider lanes and the result register. Depends on qrs_pkg and all qrs_ modules.
//
// The solver takes one equation in every clock cycle and never raises busy: a
// transfer happens at each rising edge with start high. Each equation comes out
// as one transfer marked by rsp_valid for exactly one cycle, in the order the
// equations went in. The pipeline holds the decode, multiply, discriminant and
// classify stages, the square root of the discriminant, which resolves one bit
// per stage over 33 + FRAC_BITS stages, the numerator stage, the dividers, which
// resolve one of the 48 quotient bits per stage, and the output stages. The
// receiver cannot hold a result off, so no result is ever retried. The tolerance
// register epsilon resets to 43 (about 1e-8) and must only be written while no
// equation is in flight.
module quadratic_root_solver #(
   parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [qrs_pkg::TERM_W-1:0]            req_term_count,
   input  logic signed [qrs_pkg::COEF_W-1:0]     req_coef_constant,
   input  logic signed [qrs_pkg::COEF_W-1:0]     req_coef_linear,
   input  logic signed [qrs_pkg::COEF_W-1:0]     req_coef_square,
   input  logic                                  csr_write_enable,
   input  logic [qrs_pkg::EPS_W-1:0]             csr_write_data,
   output logic                                  rsp_valid,
   output logic [qrs_pkg::STATUS_W-1:0]          rsp_status,
   output logic [qrs_pkg::COUNT_W-1:0]           rsp_root_count,
   output logic signed [qrs_pkg::ROOT_W-1:0]     rsp_root_first,
   output logic signed [qrs_pkg::ROOT_W-1:0]     rsp_root_second,
   output logic                                  rsp_overflow
);
   import qrs_pkg::*;

   localparam int NB_W    = COEF_W + FRAC_BITS + 1;
   localparam int RAD_W   = DISC_W + 2 * FRAC_BITS;
   localparam int SW      = RAD_W / 2;
   localparam int NUM_W   = COEF_W + FRAC_BITS + 3;
   // Divider: magnitude, operand and range stages, one stage per quotient bit, result.
   localparam int DIV_LAT = 3 + ROOT_W + 1;

   // The pipeline never stalls, so the solver is always ready.
   assign busy = 1'b0;

   // Tolerance register.
   logic [EPS_W-1:0] eps_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= EPS_RESET;
      end else if (csr_write_enable) begin
         eps_ff <= csr_write_data;
      end
   end

   // Decode, products, discriminant and classification.
   ctrl_type                ctrl_f;
   logic signed [NB_W-1:0]  num_f;
   logic signed [DEN_W-1:0] den_f;
   logic [RAD_W-1:0]        rad_f;

   qrs_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (start & ~busy),
      .term_count    (req_term_count),
      .coef_constant (req_coef_constant),
      .coef_linear   (req_coef_linear),
      .coef_square   (req_coef_square),
      .epsilon       (eps_ff),
      .ctrl_out      (ctrl_f),
      .num_out       (num_f),
      .den_out       (den_f),
      .rad_out       (rad_f)
   );

   // Square root of the scaled discriminant.
   ctrl_type                ctrl_s;
   logic signed [NB_W-1:0]  num_s;
   logic signed [DEN_W-1:0] den_s;
   logic [SW-1:0]           root_s;

   qrs_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .ctrl_in  (ctrl_f),
      .num_in   (num_f),
      .den_in   (den_f),
      .rad_in   (rad_f),
      .ctrl_out (ctrl_s),
      .num_out  (num_s),
      .den_out  (den_s),
      .root_out (root_s)
   );

   // Numerator stage: -b*2^F minus and plus the square root. For a single root
   // or a linear equation the first numerator is taken as it is.
   logic signed [NUM_W-1:0] nb_ext, s_ext, num1_in;
   ctrl_type                ctrl_n_ff;
   logic signed [NUM_W-1:0] num1_ff, num2_ff;
   logic signed [DEN_W-1:0] den_n_ff;

   always_comb begin
      nb_ext  = NUM_W'(num_s);
      s_ext   = NUM_W'(root_s);
      num1_in = (ctrl_s.mode == MODE_DOUBLE) ? (nb_ext - s_ext) : nb_ext;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_n_ff <= '0;
      end else begin
         ctrl_n_ff <= ctrl_s;
      end
      num1_ff  <= num1_in;
      num2_ff  <= nb_ext + s_ext;
      den_n_ff <= den_s;
   end

   // Two divider lanes; the second only matters when there are two roots.
   logic [ROOT_W-1:0] r1_d, r2_d;
   logic              ovf1_d, ovf2_d;

   qrs_div #(.FRAC_BITS(FRAC_BITS)) u_div_first (
      .clock    (clock),
      .num_in   (num1_ff),
      .den_in   (den_n_ff),
      .root_out (r1_d),
      .ovf_out  (ovf1_d)
   );

   qrs_div #(.FRAC_BITS(FRAC_BITS)) u_div_second (
      .clock    (clock),
      .num_in   (num2_ff),
      .den_in   (den_n_ff),
      .root_out (r2_d),
      .ovf_out  (ovf2_d)
   );

   // Control travels alongside the dividers in a delay line of matching length.
   ctrl_type ctrl_dly_ff [DIV_LAT];

   for (genvar k = 0; k < DIV_LAT; k++) begin : g_dly
      always_ff @(posedge clock) begin
         if (reset) begin
            ctrl_dly_ff[k] <= '0;
         end else if (k == 0) begin
            ctrl_dly_ff[k] <= ctrl_n_ff;
         end else begin
            ctrl_dly_ff[k] <= ctrl_dly_ff[(k == 0) ? 0 : k - 1];
         end
      end
   end

   // Result register: unused roots read as zero and overflow only counts roots
   // that are actually reported.
   ctrl_type          ctrl_o;
   logic              rsp_valid_ff, rsp_overflow_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [COUNT_W-1:0]  rsp_root_count_ff;
   logic [ROOT_W-1:0] rsp_root_first_ff, rsp_root_second_ff;
   logic [ROOT_W-1:0] first_in, second_in;
   logic              ovf_in;

   always_comb begin
      ctrl_o    = ctrl_dly_ff[DIV_LAT-1];
      first_in  = '0;
      second_in = '0;
      ovf_in    = 1'b0;
      case (ctrl_o.mode)
         MODE_LINEAR, MODE_SINGLE: begin
            first_in = r1_d;
            ovf_in   = ovf1_d;
         end
         MODE_DOUBLE: begin
            first_in  = r1_d;
            second_in = r2_d;
            ovf_in    = ovf1_d | ovf2_d;
         end
         default: begin
            first_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctrl_o.valid;
      end
      rsp_status_ff      <= ctrl_o.status;
      rsp_root_count_ff  <= ctrl_o.root_count;
      rsp_root_first_ff  <= first_in;
      rsp_root_second_ff <= second_in;
      rsp_overflow_ff    <= ovf_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_root_count  = rsp_root_count_ff;
   assign rsp_root_first  = rsp_root_first_ff;
   assign rsp_root_second = rsp_root_second_ff;
   assign rsp_overflow    = rsp_overflow_ff;

endmodule

### hdl/qrs_front.sv
// Front end of the solver: degree decode, coefficient products, discriminant and
// root classification over four register stages. Depends on qrs_pkg.
module qrs_front #(
   parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          in_valid,
   input  logic [qrs_pkg::TERM_W-1:0]                    term_count,
   input  logic signed [qrs_pkg::COEF_W-1:0]             coef_constant,
   input  logic signed [qrs_pkg::COEF_W-1:0]             coef_linear,
   input  logic signed [qrs_pkg::COEF_W-1:0]             coef_square,
   input  logic [qrs_pkg::EPS_W-1:0]                     epsilon,
   output qrs_pkg::ctrl_type                             ctrl_out,
   output logic signed [qrs_pkg::COEF_W+FRAC_BITS:0]     num_out,
   output logic signed [qrs_pkg::DEN_W-1:0]              den_out,
   output logic [qrs_pkg::DISC_W+2*FRAC_BITS-1:0]        rad_out
);
   import qrs_pkg::*;

   localparam int NB_W     = COEF_W + FRAC_BITS + 1;
   localparam int RAD_W    = DISC_W + 2 * FRAC_BITS;
   localparam int NZ_SHIFT = COEF_W - FRAC_BITS;
   localparam int WIDE_W   = 2 * COEF_W;
   localparam int SCMP_W   = DISC_W + EPS_W;

   function automatic logic [COEF_W-1:0] mag_of(input logic signed [COEF_W-1:0] v);
      logic [COEF_W-1:0] r;
      r = v[COEF_W-1] ? (~v + 1'b1) : v;
      return r;
   endfunction

   function automatic logic near_zero(input logic [COEF_W-1:0] m,
                                      input logic [EPS_W-1:0] e);
      logic [WIDE_W-1:0] sh;
      sh = WIDE_W'(m) << NZ_SHIFT;
      return sh < WIDE_W'(e);
   endfunction

   // Stage 0: decode.
   logic [COEF_W-1:0] am, bm, cm;
   logic              nz_a, nz_b, nz_c, quad, lin;
   ctrl_type          ctrl_in;

   ctrl_type                 ctrl0_ff, ctrl1_ff, ctrl2_ff, ctrl_out_ff;
   logic signed [COEF_W-1:0] a0_ff, b0_ff, c0_ff, a1_ff, b1_ff, c1_ff, a2_ff, b2_ff, c2_ff;
   logic [COEF_W-1:0]        am0_ff, bm0_ff, cm0_ff;
   logic                     ac_neg0_ff, ac_neg1_ff;
   logic [WIDE_W-1:0]        bsq1_ff, ac1_ff;
   logic [DISC_W-1:0]        dmag2_ff;
   logic                     dneg2_ff;
   logic signed [NB_W-1:0]   num_out_ff;
   logic signed [DEN_W-1:0]  den_out_ff;
   logic [RAD_W-1:0]         rad_out_ff;

   always_comb begin
      am   = mag_of(coef_square);
      bm   = mag_of(coef_linear);
      cm   = mag_of(coef_constant);
      nz_a = near_zero(am, epsilon);
      nz_b = near_zero(bm, epsilon);
      nz_c = near_zero(cm, epsilon);
      quad = (term_count == TERMS_QUAD) && !nz_a;
      lin  = ((term_count == TERMS_LINEAR) || ((term_count == TERMS_QUAD) && nz_a)) && !nz_b;
      ctrl_in            = '0;
      ctrl_in.valid      = in_valid;
      ctrl_in.status     = STATUS_OK;
      ctrl_in.mode       = MODE_NONE;
      ctrl_in.root_count = '0;
      case (term_count) inside
         TERMS_NONE: begin
            ctrl_in.status = STATUS_INFINITE;
         end
         TERMS_CONST, TERMS_LINEAR, TERMS_QUAD: begin
            if (quad) begin
               ctrl_in.mode       = MODE_DOUBLE;
               ctrl_in.root_count = COUNT_W'(2);
            end else if (lin) begin
               ctrl_in.mode       = MODE_LINEAR;
               ctrl_in.root_count = COUNT_W'(1);
            end else if (nz_c) begin
               ctrl_in.status = STATUS_INFINITE;
            end
         end
         default: begin
            ctrl_in.status = STATUS_BAD_DEGREE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl0_ff <= '0;
      end else begin
         ctrl0_ff <= ctrl_in;
      end
      a0_ff      <= coef_square;
      b0_ff      <= coef_linear;
      c0_ff      <= coef_constant;
      am0_ff     <= am;
      bm0_ff     <= bm;
      cm0_ff     <= cm;
      ac_neg0_ff <= (coef_square[COEF_W-1] != coef_constant[COEF_W-1])
                    && (coef_square != '0) && (coef_constant != '0);
   end

   // Stage 1: the two products.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl1_ff <= '0;
      end else begin
         ctrl1_ff <= ctrl0_ff;
      end
      bsq1_ff    <= WIDE_W'(bm0_ff) * WIDE_W'(bm0_ff);
      ac1_ff     <= WIDE_W'(am0_ff) * WIDE_W'(cm0_ff);
      ac_neg1_ff <= ac_neg0_ff;
      a1_ff      <= a0_ff;
      b1_ff      <= b0_ff;
      c1_ff      <= c0_ff;
   end

   // Stage 2: discriminant as sign and magnitude.
   logic [DISC_W-1:0] four_ac, bsq_ext, dmag_in;
   logic              dneg_in;

   always_comb begin
      four_ac = {ac1_ff, 2'b00};
      bsq_ext = DISC_W'(bsq1_ff);
      dneg_in = 1'b0;
      if (ac_neg1_ff) begin
         dmag_in = bsq_ext + four_ac;
      end else if (bsq_ext >= four_ac) begin
         dmag_in = bsq_ext - four_ac;
      end else begin
         dmag_in = four_ac - bsq_ext;
         dneg_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl2_ff <= '0;
      end else begin
         ctrl2_ff <= ctrl1_ff;
      end
      dmag2_ff <= dmag_in;
      dneg2_ff <= dneg_in;
      a2_ff    <= a1_ff;
      b2_ff    <= b1_ff;
      c2_ff    <= c1_ff;
   end

   // Stage 3: compare the discriminant with the tolerance and form the operands.
   logic [SCMP_W-1:0]      dsc, thr;
   ctrl_type               ctrl3_in;
   logic [RAD_W-1:0]       rad_in;
   logic signed [NB_W-1:0] c_ext, b_ext, num_in;
   logic signed [DEN_W-1:0] den_in;

   always_comb begin
      dsc      = {dmag2_ff, {EPS_W{1'b0}}};
      thr      = SCMP_W'(epsilon) << (2 * FRAC_BITS);
      ctrl3_in = ctrl2_ff;
      rad_in   = '0;
      c_ext    = NB_W'(c2_ff);
      b_ext    = NB_W'(b2_ff);
      if (ctrl2_ff.mode == MODE_DOUBLE) begin
         if ((dneg2_ff || (dmag2_ff == '0)) && (dsc >= thr)) begin
            ctrl3_in.mode       = MODE_NONE;
            ctrl3_in.root_count = '0;
         end else if (dneg2_ff || (dsc < thr)) begin
            ctrl3_in.mode       = MODE_SINGLE;
            ctrl3_in.root_count = COUNT_W'(1);
         end else begin
            rad_in = RAD_W'(dmag2_ff) << (2 * FRAC_BITS);
         end
      end
      if (ctrl2_ff.mode == MODE_LINEAR) begin
         num_in = -(c_ext <<< FRAC_BITS);
         den_in = DEN_W'(b2_ff);
      end else begin
         num_in = -(b_ext <<< FRAC_BITS);
         den_in = DEN_W'(a2_ff) <<< 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_out_ff <= '0;
      end else begin
         ctrl_out_ff <= ctrl3_in;
      end
      num_out_ff <= num_in;
      den_out_ff <= den_in;
      rad_out_ff <= rad_in;
   end

   assign ctrl_out = ctrl_out_ff;
   assign num_out  = num_out_ff;
   assign den_out  = den_out_ff;
   assign rad_out  = rad_out_ff;

endmodule

### hdl/qrs_sqrt.sv
// Pipelined integer square root, one result bit per register stage, with the
// item's control and divider operands carried alongside. Depends on qrs_pkg.
module qrs_sqrt #(
   parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  qrs_pkg::ctrl_type                          ctrl_in,
   input  logic signed [qrs_pkg::COEF_W+FRAC_BITS:0]  num_in,
   input  logic signed [qrs_pkg::DEN_W-1:0]           den_in,
   input  logic [qrs_pkg::DISC_W+2*FRAC_BITS-1:0]     rad_in,
   output qrs_pkg::ctrl_type                          ctrl_out,
   output logic signed [qrs_pkg::COEF_W+FRAC_BITS:0]  num_out,
   output logic signed [qrs_pkg::DEN_W-1:0]           den_out,
   output logic [(qrs_pkg::DISC_W+2*FRAC_BITS)/2-1:0] root_out
);
   import qrs_pkg::*;

   localparam int RAD_W = DISC_W + 2 * FRAC_BITS;
   localparam int SW    = RAD_W / 2;
   localparam int NB_W  = COEF_W + FRAC_BITS + 1;

   ctrl_type                ctrl_ff [SW];
   logic [RAD_W:0]          rem_ff  [SW];
   logic [SW-1:0]           root_ff [SW];
   logic signed [NB_W-1:0]  num_ff  [SW];
   logic signed [DEN_W-1:0] den_ff  [SW];

   for (genvar k = 0; k < SW; k++) begin : g_step
      localparam int BIT = SW - 1 - k;
      ctrl_type                ctrl_src;
      logic [RAD_W:0]          rem_src, trial, rem_in;
      logic [SW-1:0]           root_src, root_in;
      logic signed [NB_W-1:0]  num_src;
      logic signed [DEN_W-1:0] den_src;

      if (k == 0) begin : g_first
         assign ctrl_src = ctrl_in;
         assign rem_src  = {1'b0, rad_in};
         assign root_src = '0;
         assign num_src  = num_in;
         assign den_src  = den_in;
      end else begin : g_next
         assign ctrl_src = ctrl_ff[k-1];
         assign rem_src  = rem_ff[k-1];
         assign root_src = root_ff[k-1];
         assign num_src  = num_ff[k-1];
         assign den_src  = den_ff[k-1];
      end

      // Trial value 2*root*2^BIT + 2^(2*BIT); the remainder holds radicand - root^2.
      always_comb begin
         trial = ((RAD_W+1)'(root_src) << (BIT + 1)) | ((RAD_W+1)'(1'b1) << (2 * BIT));
         if (rem_src >= trial) begin
            rem_in  = rem_src - trial;
            root_in = root_src | (SW'(1'b1) << BIT);
         end else begin
            rem_in  = rem_src;
            root_in = root_src;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctrl_ff[k] <= '0;
         end else begin
            ctrl_ff[k] <= ctrl_src;
         end
         rem_ff[k]  <= rem_in;
         root_ff[k] <= root_in;
         num_ff[k]  <= num_src;
         den_ff[k]  <= den_src;
      end
   end

   assign ctrl_out = ctrl_ff[SW-1];
   assign num_out  = num_ff[SW-1];
   assign den_out  = den_ff[SW-1];
   assign root_out = root_ff[SW-1];

endmodule

### hdl/qrs_div.sv
// Pipelined signed divider with round-to-nearest and 48-bit saturation, one
// quotient bit per register stage. Depends on qrs_pkg.
module qrs_div #(
   parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                       clock,
   input  logic signed [qrs_pkg::COEF_W+FRAC_BITS+2:0] num_in,
   input  logic signed [qrs_pkg::DEN_W-1:0]           den_in,
   output logic [qrs_pkg::ROOT_W-1:0]                 root_out,
   output logic                                       ovf_out
);
   import qrs_pkg::*;

   localparam int NUM_W = COEF_W + FRAC_BITS + 3;
   localparam int MAG_W = NUM_W - 1;
   localparam int X_W   = NUM_W + 1;
   localparam int DM_W  = DEN_W - 1;
   localparam int Y_W   = DEN_W;
   localparam int CMP_W = Y_W + ROOT_W;

   localparam logic [ROOT_W-1:0] ROOT_MAX = {1'b0, {(ROOT_W-1){1'b1}}};
   localparam logic [ROOT_W-1:0] ROOT_MIN = {1'b1, {(ROOT_W-1){1'b0}}};

   typedef struct packed {
      logic neg;
      logic num_neg;
      logic num_zero;
      logic den_zero;
      logic big;
   } div_flag_type;

   // Stage A: magnitudes and signs.
   logic [NUM_W-1:0]  nm_full;
   logic [DEN_W-1:0]  dm_full;
   logic [MAG_W-1:0]  nm_a_ff;
   logic [DM_W-1:0]   dm_a_ff;
   div_flag_type      flag_a_ff, flag_b_ff, flag_c_ff;
   div_flag_type      flag_a_in, flag_c_in;
   logic [X_W-1:0]    x_b_ff, x_c_ff;
   logic [Y_W-1:0]    y_b_ff, y_c_ff;

   always_comb begin
      nm_full            = num_in[NUM_W-1] ? (~num_in + 1'b1) : num_in;
      dm_full            = den_in[DEN_W-1] ? (~den_in + 1'b1) : den_in;
      flag_a_in.neg      = num_in[NUM_W-1] ^ den_in[DEN_W-1];
      flag_a_in.num_neg  = num_in[NUM_W-1];
      flag_a_in.num_zero = (num_in == '0);
      flag_a_in.den_zero = (den_in == '0);
      flag_a_in.big      = 1'b0;
   end

   always_ff @(posedge clock) begin
      nm_a_ff   <= nm_full[MAG_W-1:0];
      dm_a_ff   <= dm_full[DM_W-1:0];
      flag_a_ff <= flag_a_in;
   end

   // Stage B: the rounding numerator 2n+d and the divisor 2d.
   always_ff @(posedge clock) begin
      x_b_ff    <= {nm_a_ff, 1'b0} + X_W'(dm_a_ff);
      y_b_ff    <= {dm_a_ff, 1'b0};
      flag_b_ff <= flag_a_ff;
   end

   // Stage C: a quotient of 2^48 or more saturates whatever its sign.
   always_comb begin
      flag_c_in     = flag_b_ff;
      flag_c_in.big = CMP_W'(x_b_ff) >= (CMP_W'(y_b_ff) << ROOT_W);
   end

   always_ff @(posedge clock) begin
      x_c_ff    <= x_b_ff;
      y_c_ff    <= y_b_ff;
      flag_c_ff <= flag_c_in;
   end

   // Restoring division, most significant quotient bit first.
   logic [X_W-1:0]    rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] quo_ff  [ROOT_W];
   logic [Y_W-1:0]    y_ff    [ROOT_W];
   div_flag_type      flag_ff [ROOT_W];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_step
      localparam int BIT = ROOT_W - 1 - k;
      logic [X_W-1:0]    rem_src, rem_in;
      logic [ROOT_W-1:0] quo_src, quo_in;
      logic [Y_W-1:0]    y_src;
      div_flag_type      flag_src;
      logic [CMP_W-1:0]  trial, diff;

      if (k == 0) begin : g_first
         assign rem_src  = x_c_ff;
         assign quo_src  = '0;
         assign y_src    = y_c_ff;
         assign flag_src = flag_c_ff;
      end else begin : g_next
         assign rem_src  = rem_ff[k-1];
         assign quo_src  = quo_ff[k-1];
         assign y_src    = y_ff[k-1];
         assign flag_src = flag_ff[k-1];
      end

      always_comb begin
         trial = CMP_W'(y_src) << BIT;
         diff  = CMP_W'(rem_src) - trial;
         if (CMP_W'(rem_src) >= trial) begin
            rem_in = diff[X_W-1:0];
            quo_in = quo_src | (ROOT_W'(1'b1) << BIT);
         end else begin
            rem_in = rem_src;
            quo_in = quo_src;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k]  <= rem_in;
         quo_ff[k]  <= quo_in;
         y_ff[k]    <= y_src;
         flag_ff[k] <= flag_src;
      end
   end

   // Final stage: sign, saturation and the zero-divisor case.
   logic [ROOT_W-1:0] q, root_in;
   logic              ovf_in;
   div_flag_type      fl;
   logic [ROOT_W-1:0] root_ff;
   logic              ovf_ff;

   always_comb begin
      q       = quo_ff[ROOT_W-1];
      fl      = flag_ff[ROOT_W-1];
      ovf_in  = 1'b0;
      root_in = q;
      if (fl.den_zero) begin
         ovf_in = 1'b1;
         if (fl.num_zero) begin
            root_in = '0;
         end else begin
            root_in = fl.num_neg ? ROOT_MIN : ROOT_MAX;
         end
      end else if (fl.big) begin
         ovf_in  = 1'b1;
         root_in = fl.neg ? ROOT_MIN : ROOT_MAX;
      end else if (fl.neg && (q != '0)) begin
         if (q > ROOT_MIN) begin
            ovf_in  = 1'b1;
            root_in = ROOT_MIN;
         end else begin
            root_in = ~q + 1'b1;
         end
      end else if (!fl.neg && (q > ROOT_MAX)) begin
         ovf_in  = 1'b1;
         root_in = ROOT_MAX;
      end
   end

   always_ff @(posedge clock) begin
      root_ff <= root_in;
      ovf_ff  <= ovf_in;
   end

   assign root_out = root_ff;
   assign ovf_out  = ovf_ff;

endmodule
